FILE: hw/rtl/sirp_pkg.sv
// ----------------------------------------------------------------------------
// Sensor init record parser package
// Shared types and constants for the script parser front end, queue and
// back end.
// ----------------------------------------------------------------------------
package sirp_pkg;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DELAY = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  // Packet count that marks a delay record.
  localparam logic [31:0] DELAY_MARK = 32'hFFFF_FFFF;

  // Index of the granularity byte within the record header.
  localparam logic [2:0] HDR_GRAN_POS = 3'd4;

  // One classified item, passed from the front end to the back end.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       pkt_first;
    logic       pkt_last;
    logic       script_end;
    logic       truncated;
  } cmd_t;

endpackage : sirp_pkg

FILE: hw/rtl/sirp_in_if.sv
// ----------------------------------------------------------------------------
// Script byte channel
// Valid/ready channel that carries one script byte and its end-of-buffer mark.
// ----------------------------------------------------------------------------
interface sirp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_buffer;

  modport source (output valid, output data_byte, output last_in_buffer, input ready);
  modport sink (input valid, input data_byte, input last_in_buffer, output ready);
endinterface : sirp_in_if

FILE: hw/rtl/sirp_out_if.sv
// ----------------------------------------------------------------------------
// Parser result channel
// Valid/ready channel that carries one write, delay or end-of-script item.
// ----------------------------------------------------------------------------
interface sirp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] device_address;
  logic [7:0] write_byte;
  logic       packet_first;
  logic       packet_last;
  logic [7:0] delay_ms;
  logic       script_end;
  logic       truncated;

  modport source (
    output valid, output kind, output device_address, output write_byte,
    output packet_first, output packet_last, output delay_ms,
    output script_end, output truncated, input ready
  );
  modport sink (
    input valid, input kind, input device_address, input write_byte,
    input packet_first, input packet_last, input delay_ms,
    input script_end, input truncated, output ready
  );
endinterface : sirp_out_if

FILE: hw/rtl/sensor_init_record_parser.sv
// ----------------------------------------------------------------------------
// Sensor init record parser
// Path: a result item is registered in the command queue and then in the back end output register.
// Throughput: one script byte per cycle while the command queue has room; the
// front end parses each byte as it is taken and the queue absorbs output stalls until it fills.
// Reset: asynchronous, active low; parse state and device address clear to 0.
// ----------------------------------------------------------------------------
module sensor_init_record_parser #(
  parameter int QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  sirp_in_if.sink    in_i,
  sirp_out_if.source out_o
);

  logic           push_valid;
  logic           push_ready;
  sirp_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  sirp_pkg::cmd_t pop_cmd;

  // Byte parsing and classification.
  sirp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  // Command queue between the two halves.
  sirp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  // Result formatting and output register.
  sirp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_o       (out_o)
  );

endmodule : sensor_init_record_parser

FILE: hw/rtl/sirp_front.sv
// ----------------------------------------------------------------------------
// Parser front end
// Accepts script bytes, tracks header and record position and turns write
// payload bytes, delay values and the final byte into back end commands.
// ----------------------------------------------------------------------------
module sirp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  sirp_in_if.sink         in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output sirp_pkg::cmd_t  push_cmd_o
);

  logic [2:0]  hdr_pos_q, hdr_pos_d;
  logic [31:0] count_q, count_d;
  logic [7:0]  gran_q, gran_d;
  logic [31:0] remain_q, remain_d;
  logic [7:0]  byte_idx_q, byte_idx_d;
  logic        in_payload_q, in_payload_d;
  logic        is_delay_q, is_delay_d;

  logic        accept;
  logic        have;
  logic        pkt_first;
  logic        pkt_last;
  logic        hdr_delay;
  logic [31:0] hdr_remain;
  sirp_pkg::cmd_t cmd;

  // A byte is taken whenever the queue has room.
  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && push_ready_i;

  // Record parsing for the byte on the input.
  always_comb begin
    hdr_pos_d    = hdr_pos_q;
    count_d      = count_q;
    gran_d       = gran_q;
    remain_d     = remain_q;
    byte_idx_d   = byte_idx_q;
    in_payload_d = in_payload_q;
    is_delay_d   = is_delay_q;
    have         = 1'b0;
    cmd          = '0;
    cmd.kind     = sirp_pkg::KIND_WRITE;
    cmd.data     = in_i.data_byte;
    pkt_first    = (byte_idx_q == 8'd0);
    pkt_last     = (({1'b0, byte_idx_q} + 9'd1) >= {1'b0, gran_q});
    hdr_delay    = (count_q == sirp_pkg::DELAY_MARK);
    hdr_remain   = '0;

    if (!in_payload_q) begin
      if (hdr_pos_q < sirp_pkg::HDR_GRAN_POS) begin
        // Count bytes arrive least significant first.
        case (hdr_pos_q[1:0])
          2'd0:    count_d[7:0]   = count_q[7:0]   | in_i.data_byte;
          2'd1:    count_d[15:8]  = count_q[15:8]  | in_i.data_byte;
          2'd2:    count_d[23:16] = count_q[23:16] | in_i.data_byte;
          default: count_d[31:24] = count_q[31:24] | in_i.data_byte;
        endcase
        hdr_pos_d = hdr_pos_q + 3'd1;
      end else begin
        // Granularity byte closes the header.
        if (in_i.data_byte == 8'd0) begin
          hdr_remain = '0;
        end else if (hdr_delay) begin
          hdr_remain = 32'd1;
        end else begin
          hdr_remain = count_q;
        end
        gran_d       = in_i.data_byte;
        is_delay_d   = hdr_delay;
        remain_d     = hdr_remain;
        byte_idx_d   = '0;
        hdr_pos_d    = '0;
        count_d      = '0;
        in_payload_d = (hdr_remain != 32'd0);
      end
    end else begin
      // Payload byte: a write, or the delay value on a delay record.
      if (is_delay_q) begin
        if (pkt_first) begin
          have     = 1'b1;
          cmd.kind = sirp_pkg::KIND_DELAY;
        end
      end else begin
        have          = 1'b1;
        cmd.pkt_first = pkt_first;
        cmd.pkt_last  = pkt_last;
      end
      if (pkt_last) begin
        byte_idx_d = '0;
        remain_d   = remain_q - 32'd1;
        if (remain_d == 32'd0) begin
          in_payload_d = 1'b0;
          is_delay_d   = 1'b0;
        end
      end else begin
        byte_idx_d = byte_idx_q + 8'd1;
      end
    end

    // The final byte always yields an item and restarts the parse.
    if (in_i.last_in_buffer) begin
      cmd.truncated  = in_payload_d || (hdr_pos_d != 3'd0);
      cmd.script_end = 1'b1;
      if (!have) begin
        have     = 1'b1;
        cmd.kind = sirp_pkg::KIND_END;
      end
      hdr_pos_d    = '0;
      count_d      = '0;
      gran_d       = '0;
      remain_d     = '0;
      byte_idx_d   = '0;
      in_payload_d = 1'b0;
      is_delay_d   = 1'b0;
    end
  end

  assign push_valid_o = accept && have;
  assign push_cmd_o   = cmd;

  // Parse state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_pos_q    <= '0;
      count_q      <= '0;
      gran_q       <= '0;
      remain_q     <= '0;
      byte_idx_q   <= '0;
      in_payload_q <= 1'b0;
      is_delay_q   <= 1'b0;
    end else if (accept) begin
      hdr_pos_q    <= hdr_pos_d;
      count_q      <= count_d;
      gran_q       <= gran_d;
      remain_q     <= remain_d;
      byte_idx_q   <= byte_idx_d;
      in_payload_q <= in_payload_d;
      is_delay_q   <= is_delay_d;
    end
  end

endmodule : sirp_front

FILE: hw/rtl/sirp_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Small register FIFO between the parser front end and back end.
// ----------------------------------------------------------------------------
module sirp_queue #(
  parameter int Depth = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  sirp_pkg::cmd_t  push_cmd_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output sirp_pkg::cmd_t  pop_cmd_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  sirp_pkg::cmd_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule : sirp_queue

FILE: hw/rtl/sirp_back.sv
// ----------------------------------------------------------------------------
// Parser back end
// Holds the device address register and turns queued commands into
// registered result items.
// ----------------------------------------------------------------------------
module sirp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [6:0]      cfg_wdata_i,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  sirp_pkg::cmd_t  pop_cmd_i,
  sirp_out_if.source      out_o
);

  logic [6:0]     dev_addr_q;
  logic           out_valid_q, out_valid_d;
  sirp_pkg::cmd_t out_cmd_q;
  logic [6:0]     out_addr_q;
  logic           load;

  // Device address register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_wdata_i;
    end
  end

  // The output register refills whenever it is empty or being drained.
  assign pop_ready_o = !out_valid_q || out_o.ready;
  assign load        = pop_valid_i && pop_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_cmd_q  <= pop_cmd_i;
      out_addr_q <= dev_addr_q;
    end
  end

  // Fields that do not apply to the item kind read as zero.
  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = out_cmd_q.kind;
  assign out_o.device_address =
      (out_cmd_q.kind == sirp_pkg::KIND_WRITE) ? out_addr_q : 7'd0;
  assign out_o.write_byte     =
      (out_cmd_q.kind == sirp_pkg::KIND_WRITE) ? out_cmd_q.data : 8'd0;
  assign out_o.delay_ms       =
      (out_cmd_q.kind == sirp_pkg::KIND_DELAY) ? out_cmd_q.data : 8'd0;
  assign out_o.packet_first   = out_cmd_q.pkt_first;
  assign out_o.packet_last    = out_cmd_q.pkt_last;
  assign out_o.script_end     = out_cmd_q.script_end;
  assign out_o.truncated      = out_cmd_q.truncated;

endmodule : sirp_back
